[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is asserted.
`define GTRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Concurrent assertion that is also evaluated during the reset.
`define GTRR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

[design/gtrr_pkg.sv]
package gtrr_pkg;

   localparam int MAX_GLYPH_W = 32;
   localparam int MAX_GLYPH_H = 64;
   localparam int BUF_W       = MAX_GLYPH_W + 8;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   localparam logic [2:0] CSR_FIRST_CHAR   = 3'd0;
   localparam logic [2:0] CSR_LAST_CHAR    = 3'd1;
   localparam logic [2:0] CSR_LINE_ADVANCE = 3'd2;
   localparam logic [2:0] CSR_X_SCALE      = 3'd3;
   localparam logic [2:0] CSR_Y_SCALE      = 3'd4;
   localparam logic [2:0] CSR_DRAW_COLOR   = 3'd5;

   typedef enum logic [1:0] {
      MODE_DRAW   = 2'd0,
      MODE_BITMAP = 2'd1,
      MODE_GLYPH  = 2'd2,
      MODE_CURSOR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_ROW     = 3'd0,
      STAT_NEWLINE = 3'd1,
      STAT_CR      = 3'd2,
      STAT_UNPRINT = 3'd3,
      STAT_DONE    = 3'd4
   } status_type;

   typedef struct packed {
      logic [12:0]        offset;
      logic [5:0]         width;
      logic [6:0]         height;
      logic [7:0]         x_advance;
      logic signed [7:0]  x_offset;
      logic signed [7:0]  y_offset;
   } glyph_rec_type;

   typedef struct packed {
      mode_type           mode;
      logic [7:0]         char_code;
      logic [12:0]        table_index;
      logic [7:0]         bitmap_byte;
      glyph_rec_type      glyph;
      logic signed [15:0] cursor_x;
      logic signed [15:0] cursor_y;
   } item_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_SINGLE,
      CS_SETUP,
      CS_REDUCE,
      CS_ROWS
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic glyph_rd;
      logic single;
      logic setup;
      logic reduce;
      logic fetch;
      logic emit_row;
   } cmd_type;

   typedef struct packed {
      logic is_glyph;
      logic out_free;
      logic ptr_high;
      logic need_byte;
      logic row_ready;
      logic last_row;
   } sts_type;

endpackage

[design/glyph_text_row_renderer.sv]
// Channel   Direction  Handshake              Contents
// req_*     in         req_valid / req_stall  draw, bitmap load, glyph load or cursor item
// rsp_*     out        rsp_valid / rsp_stall  one result per glyph row, else one status
// csr_*     in         csr_valid / csr_ready  register index and write data
//
// One item is in work at a time. A status-only item is decoded, then issues its status.
// A drawn glyph is decoded and set up, then reads bitmap bytes and issues its rows; the
// bitmap store delivers one byte per cycle while a row still needs bits.
// A glyph offset at or beyond BITMAP_DEPTH is first reduced by subtracting the depth.
// Reset is synchronous; it clears the pen, margin and handshake state and sets the registers to defaults.
// A stalled result holds back the next result; a new item waits for idle.
module glyph_text_row_renderer #(
   parameter int BITMAP_DEPTH = 8192,
   parameter int GLYPH_COUNT  = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_char_code,
   input  logic [12:0]        req_table_index,
   input  logic [7:0]         req_bitmap_byte,
   input  logic [12:0]        req_glyph_offset,
   input  logic [5:0]         req_glyph_width,
   input  logic [6:0]         req_glyph_height,
   input  logic [7:0]         req_glyph_x_advance,
   input  logic signed [7:0]  req_glyph_x_offset,
   input  logic signed [7:0]  req_glyph_y_offset,
   input  logic signed [15:0] req_cursor_x,
   input  logic signed [15:0] req_cursor_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [15:0] rsp_row_x,
   output logic signed [15:0] rsp_row_y,
   output logic [31:0]        rsp_row_mask,
   output logic [5:0]         rsp_row_width,
   output logic [31:0]        rsp_pixel_color,
   output logic signed [15:0] rsp_pen_x_after,
   output logic signed [15:0] rsp_pen_y_after,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import gtrr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   gtrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   gtrr_datapath #(
      .BITMAP_DEPTH (BITMAP_DEPTH),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_table_index     (req_table_index),
      .req_bitmap_byte     (req_bitmap_byte),
      .req_glyph_offset    (req_glyph_offset),
      .req_glyph_width     (req_glyph_width),
      .req_glyph_height    (req_glyph_height),
      .req_glyph_x_advance (req_glyph_x_advance),
      .req_glyph_x_offset  (req_glyph_x_offset),
      .req_glyph_y_offset  (req_glyph_y_offset),
      .req_cursor_x        (req_cursor_x),
      .req_cursor_y        (req_cursor_y),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_row_x           (rsp_row_x),
      .rsp_row_y           (rsp_row_y),
      .rsp_row_mask        (rsp_row_mask),
      .rsp_row_width       (rsp_row_width),
      .rsp_pixel_color     (rsp_pixel_color),
      .rsp_pen_x_after     (rsp_pen_x_after),
      .rsp_pen_y_after     (rsp_pen_y_after),
      .rsp_last            (rsp_last)
   );

endmodule

[design/gtrr_datapath.sv]
module gtrr_datapath #(
   parameter int BITMAP_DEPTH = 8192,
   parameter int GLYPH_COUNT  = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  gtrr_pkg::cmd_type  cmd,
   output gtrr_pkg::sts_type  sts,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_char_code,
   input  logic [12:0]        req_table_index,
   input  logic [7:0]         req_bitmap_byte,
   input  logic [12:0]        req_glyph_offset,
   input  logic [5:0]         req_glyph_width,
   input  logic [6:0]         req_glyph_height,
   input  logic [7:0]         req_glyph_x_advance,
   input  logic signed [7:0]  req_glyph_x_offset,
   input  logic signed [7:0]  req_glyph_y_offset,
   input  logic signed [15:0] req_cursor_x,
   input  logic signed [15:0] req_cursor_y,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [15:0] rsp_row_x,
   output logic signed [15:0] rsp_row_y,
   output logic [31:0]        rsp_row_mask,
   output logic [5:0]         rsp_row_width,
   output logic [31:0]        rsp_pixel_color,
   output logic signed [15:0] rsp_pen_x_after,
   output logic signed [15:0] rsp_pen_y_after,
   output logic               rsp_last
);
   import gtrr_pkg::*;

   localparam int AW = $clog2(BITMAP_DEPTH);
   localparam int GW = $clog2(GLYPH_COUNT);
   localparam int PW = (AW > 13) ? AW : 13;
   localparam int HW = $clog2(BUF_W + 1);

   logic [7:0]          first_char_ff, last_char_ff, line_adv_ff;
   logic [3:0]          x_scale_ff, y_scale_ff;
   logic [31:0]         color_ff;
   item_type            item_ff;
   logic [7:0]          bmp_ram_ff [BITMAP_DEPTH];
   glyph_rec_type       glyph_ram_ff [GLYPH_COUNT];
   glyph_rec_type       glyph_q_ff;
   logic [7:0]          bmp_q_ff;
   logic                pend_ff;
   logic [PW-1:0]       ptr_ff;
   logic [BUF_W-1:0]    buf_ff;
   logic [HW-1:0]       have_ff;
   logic [5:0]          wid_ff, wbits_ff;
   logic [6:0]          rows_ff;
   logic [15:0]         rx_ff, ry_ff;
   logic [15:0]         pen_x_ff, pen_y_ff, margin_ff;
   logic [15:0]         pen_x_in, pen_y_in, margin_in;
   logic                out_valid_ff;
   status_type          out_status_ff;
   logic [15:0]         out_x_ff, out_y_ff, out_pen_x_ff, out_pen_y_ff;
   logic [31:0]         out_mask_ff, out_color_ff;
   logic [5:0]          out_width_ff;
   logic                out_last_ff;

   logic [3:0]          xs, ys;
   logic [8:0]          gofs;
   logic                in_font, is_glyph;
   status_type          single_stat;
   logic [5:0]          w_sat;
   logic [6:0]          h_sat;
   logic signed [12:0]  xoff_prod, yoff_prod;
   logic [11:0]         la_prod, xadv_prod;
   logic [MAX_GLYPH_W-1:0] raw_mask, row_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_char_ff <= 8'd32;
         last_char_ff  <= 8'd126;
         line_adv_ff   <= 8'd8;
         x_scale_ff    <= 4'd1;
         y_scale_ff    <= 4'd1;
         color_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_CHAR:   first_char_ff <= csr_data[7:0];
            CSR_LAST_CHAR:    last_char_ff  <= csr_data[7:0];
            CSR_LINE_ADVANCE: line_adv_ff   <= csr_data[7:0];
            CSR_X_SCALE:      x_scale_ff    <= csr_data[3:0];
            CSR_Y_SCALE:      y_scale_ff    <= csr_data[3:0];
            CSR_DRAW_COLOR:   color_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff.mode              <= mode_type'(req_mode);
         item_ff.char_code         <= req_char_code;
         item_ff.table_index       <= req_table_index;
         item_ff.bitmap_byte       <= req_bitmap_byte;
         item_ff.glyph.offset      <= req_glyph_offset;
         item_ff.glyph.width       <= req_glyph_width;
         item_ff.glyph.height      <= req_glyph_height;
         item_ff.glyph.x_advance   <= req_glyph_x_advance;
         item_ff.glyph.x_offset    <= req_glyph_x_offset;
         item_ff.glyph.y_offset    <= req_glyph_y_offset;
         item_ff.cursor_x          <= req_cursor_x;
         item_ff.cursor_y          <= req_cursor_y;
      end
   end

   assign xs = (x_scale_ff == 4'd0) ? 4'd1 : x_scale_ff;
   assign ys = (y_scale_ff == 4'd0) ? 4'd1 : y_scale_ff;

   assign gofs    = {1'b0, item_ff.char_code} - {1'b0, first_char_ff};
   assign in_font = (item_ff.char_code >= first_char_ff) &&
                    (item_ff.char_code <= last_char_ff) &&
                    (gofs < 9'(GLYPH_COUNT));

   always_comb begin
      single_stat = STAT_DONE;
      is_glyph    = 1'b0;
      if (item_ff.mode == MODE_DRAW) begin
         if (item_ff.char_code == CHAR_NEWLINE) begin
            single_stat = STAT_NEWLINE;
         end else if (item_ff.char_code == CHAR_CR) begin
            single_stat = STAT_CR;
         end else if (!in_font) begin
            single_stat = STAT_UNPRINT;
         end else begin
            is_glyph = 1'b1;
         end
      end
   end

   // Font stores: written by load items, read with a registered port.
   always_ff @(posedge clock) begin
      if (cmd.single && item_ff.mode == MODE_BITMAP &&
          {4'b0, item_ff.table_index} < 17'(BITMAP_DEPTH)) begin
         bmp_ram_ff[AW'(item_ff.table_index)] <= item_ff.bitmap_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         bmp_q_ff <= bmp_ram_ff[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single && item_ff.mode == MODE_GLYPH &&
          {1'b0, item_ff.table_index} < 14'(GLYPH_COUNT)) begin
         glyph_ram_ff[item_ff.table_index[GW-1:0]] <= item_ff.glyph;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_rd) begin
         glyph_q_ff <= glyph_ram_ff[gofs[GW-1:0]];
      end
   end

   assign w_sat = (glyph_q_ff.width > 6'(MAX_GLYPH_W)) ? 6'(MAX_GLYPH_W) : glyph_q_ff.width;
   assign h_sat = (glyph_q_ff.height > 7'(MAX_GLYPH_H)) ? 7'(MAX_GLYPH_H) : glyph_q_ff.height;

   assign xoff_prod = $signed(glyph_q_ff.x_offset) * $signed({1'b0, xs});
   assign yoff_prod = $signed(glyph_q_ff.y_offset) * $signed({1'b0, ys});
   assign la_prod   = {4'b0, line_adv_ff} * {8'b0, ys};
   assign xadv_prod = {4'b0, glyph_q_ff.x_advance} * {8'b0, xs};

   always_comb begin
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      margin_in = margin_ff;
      if (cmd.single && item_ff.mode == MODE_CURSOR) begin
         pen_x_in  = item_ff.cursor_x;
         margin_in = item_ff.cursor_x;
         pen_y_in  = item_ff.cursor_y;
      end else if (cmd.single && single_stat == STAT_NEWLINE) begin
         pen_x_in = margin_ff;
         pen_y_in = pen_y_ff + {4'b0, la_prod};
      end else if (cmd.setup) begin
         pen_x_in = pen_x_ff + {4'b0, xadv_prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         margin_ff <= '0;
      end else begin
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         margin_ff <= margin_in;
      end
   end

   // Per-glyph row state.
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         rx_ff    <= pen_x_ff + 16'(xoff_prod);
         ry_ff    <= pen_y_ff + {4'b0, la_prod} + 16'(yoff_prod) - 16'd1;
         wid_ff   <= w_sat;
         wbits_ff <= (h_sat == 7'd0) ? 6'd0 : w_sat;
         rows_ff  <= (h_sat == 7'd0) ? 7'd1 : h_sat;
      end else if (cmd.emit_row) begin
         ry_ff   <= ry_ff + {12'b0, ys};
         rows_ff <= rows_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         ptr_ff <= PW'(glyph_q_ff.offset);
      end else if (cmd.reduce) begin
         ptr_ff <= ptr_ff - PW'(BITMAP_DEPTH);
      end else if (cmd.fetch) begin
         ptr_ff <= (ptr_ff == PW'(BITMAP_DEPTH - 1)) ? '0 : ptr_ff + PW'(1);
      end
   end

   // Bit buffer, MSB aligned: the oldest unread glyph bit sits at the top.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         have_ff <= '0;
      end else begin
         pend_ff <= cmd.fetch;
         if (cmd.setup) begin
            buf_ff  <= '0;
            have_ff <= '0;
         end else if (cmd.emit_row) begin
            buf_ff  <= buf_ff << wbits_ff;
            have_ff <= have_ff - HW'(wbits_ff);
         end else if (pend_ff) begin
            buf_ff  <= buf_ff | ({bmp_q_ff, (BUF_W - 8)'(0)} >> have_ff);
            have_ff <= have_ff + HW'(8);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_GLYPH_W; i++) begin
         raw_mask[i] = buf_ff[BUF_W-1-i];
      end
   end

   assign row_mask = raw_mask & ~({MAX_GLYPH_W{1'b1}} << wbits_ff);

   assign sts.is_glyph  = is_glyph;
   assign sts.out_free  = !out_valid_ff || !rsp_stall;
   assign sts.ptr_high  = {1'b0, ptr_ff} >= (PW + 1)'(BITMAP_DEPTH);
   assign sts.need_byte = ({1'b0, have_ff} + (pend_ff ? (HW + 1)'(8) : '0)) <
                          (HW + 1)'(wbits_ff);
   assign sts.row_ready = !pend_ff && (have_ff >= HW'(wbits_ff));
   assign sts.last_row  = (rows_ff == 7'd1);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.single || cmd.emit_row) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single) begin
         out_status_ff <= single_stat;
         out_x_ff      <= '0;
         out_y_ff      <= '0;
         out_mask_ff   <= '0;
         out_width_ff  <= '0;
         out_color_ff  <= '0;
         out_pen_x_ff  <= pen_x_in;
         out_pen_y_ff  <= pen_y_in;
         out_last_ff   <= 1'b1;
      end else if (cmd.emit_row) begin
         out_status_ff <= STAT_ROW;
         out_x_ff      <= rx_ff;
         out_y_ff      <= ry_ff;
         out_mask_ff   <= 32'(row_mask);
         out_width_ff  <= wid_ff;
         out_color_ff  <= color_ff;
         out_pen_x_ff  <= pen_x_ff;
         out_pen_y_ff  <= pen_y_ff;
         out_last_ff   <= rows_ff == 7'd1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_row_x       = out_x_ff;
   assign rsp_row_y       = out_y_ff;
   assign rsp_row_mask    = out_mask_ff;
   assign rsp_row_width   = out_width_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_pen_x_after = out_pen_x_ff;
   assign rsp_pen_y_after = out_pen_y_ff;
   assign rsp_last        = out_last_ff;

endmodule

[design/gtrr_ctrl.sv]
module gtrr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output gtrr_pkg::cmd_type cmd,
   input  gtrr_pkg::sts_type sts
);
   import gtrr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_DECODE;
         end
         CS_DECODE: begin
            state_in = sts.is_glyph ? CS_SETUP : CS_SINGLE;
         end
         CS_SINGLE: begin
            if (sts.out_free) state_in = CS_IDLE;
         end
         CS_SETUP: begin
            state_in = CS_REDUCE;
         end
         CS_REDUCE: begin
            if (!sts.ptr_high) state_in = CS_ROWS;
         end
         CS_ROWS: begin
            if (sts.row_ready && sts.out_free && sts.last_row) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CS_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         CS_DECODE: cmd.glyph_rd = 1'b1;
         CS_SINGLE: cmd.single   = sts.out_free;
         CS_SETUP:  cmd.setup    = 1'b1;
         CS_REDUCE: cmd.reduce   = sts.ptr_high;
         CS_ROWS: begin
            cmd.fetch    = sts.need_byte;
            cmd.emit_row = sts.row_ready && sts.out_free;
         end
         default: ;
      endcase
   end

endmodule

[design/gtrr_checker.sv]
`include "assert_macros.svh"

module gtrr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_mode,
   input logic [7:0]         req_char_code,
   input logic [12:0]        req_table_index,
   input logic [7:0]         req_bitmap_byte,
   input logic [12:0]        req_glyph_offset,
   input logic [5:0]         req_glyph_width,
   input logic [6:0]         req_glyph_height,
   input logic [7:0]         req_glyph_x_advance,
   input logic signed [7:0]  req_glyph_x_offset,
   input logic signed [7:0]  req_glyph_y_offset,
   input logic signed [15:0] req_cursor_x,
   input logic signed [15:0] req_cursor_y,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic signed [15:0] rsp_row_x,
   input logic signed [15:0] rsp_row_y,
   input logic [31:0]        rsp_row_mask,
   input logic [5:0]         rsp_row_width,
   input logic [31:0]        rsp_pixel_color,
   input logic signed [15:0] rsp_pen_x_after,
   input logic signed [15:0] rsp_pen_y_after,
   input logic               rsp_last,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [2:0]         csr_index,
   input logic [31:0]        csr_data
);
   import gtrr_pkg::*;

   `GTRR_ASSERT_ALWAYS(a_no_result_after_reset, clock, $past(reset) |-> !rsp_valid)

   `GTRR_ASSERT(a_stalled_result_holds, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_mask) && $stable(rsp_status))

   `GTRR_ASSERT(a_one_item_at_a_time, clock, reset, req_valid && !req_stall |=> req_stall)

   `GTRR_ASSERT(a_status_result_clean, clock, reset,
      rsp_valid && rsp_status != STAT_ROW |-> rsp_last && rsp_row_mask == 32'd0 && rsp_row_width == 6'd0)

   `GTRR_ASSERT(a_mask_within_width, clock, reset,
      rsp_valid && rsp_status == STAT_ROW |-> rsp_row_width <= 6'(MAX_GLYPH_W) && (rsp_row_mask >> rsp_row_width) == 32'd0)

endmodule

bind glyph_text_row_renderer gtrr_checker u_gtrr_checker (.*);
